// ----- hw/rtl/tfn_pkg.sv -----
// Shared widths for the triangle face normal pipeline.
`default_nettype none
package tfn_pkg;
    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_W         = 16;
    localparam int EDGE_W  = COORD_BITS + 1;            // corner differences
    localparam int PROD_W  = 2 * EDGE_W;                // edge products
    localparam int CROSS_W = PROD_W + 1;                // signed cross component
    localparam int MAG_W   = PROD_W;                    // |cross component|
    localparam int SQ_W    = 2 * MAG_W;                 // component squared
    localparam int LEN_W   = SQ_W + 2;                  // squared length
    localparam int QW      = NORMAL_FRAC_BITS + 2;      // bits of floor(2|c_i|2^F/|c|)
    localparam int RW      = LEN_W + 2 * QW + 2;        // root remainder width
    localparam int NST     = 6 + QW;                    // pipeline stages
endpackage
`default_nettype wire

// ----- hw/rtl/tfn_root.sv -----
// One lane of the rounded-ratio root: floor(2|c_i|2^F/|c|), one bit per stage.
`default_nettype none
module tfn_root
    import tfn_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic [SQ_W-1:0]           sq,
    input  wire logic [LEN_W-1:0]          len2,
    output logic      [NORMAL_FRAC_BITS:0] q
);
    // remainder R = t^2 - m^2 L, running product S = m L
    logic [RW-1:0]    r_w [0:QW];
    logic [RW-1:0]    s_w [0:QW];
    logic [QW-1:0]    m_w [0:QW];
    logic [LEN_W-1:0] l_w [0:QW];
    logic [RW-1:0]    r_reg [0:QW-1];
    logic [RW-1:0]    s_reg [0:QW-1];
    logic [QW-1:0]    m_reg [0:QW-1];
    logic [LEN_W-1:0] l_reg [0:QW-1];
    logic [QW-1:0]    m_inc;

    assign r_w[0] = RW'(sq) << (2 * NORMAL_FRAC_BITS + 2);
    assign s_w[0] = '0;
    assign m_w[0] = '0;
    assign l_w[0] = len2;

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int K = QW - 1 - j;
        logic [RW-1:0] lsh;
        logic [RW-1:0] d;
        logic          ge;

        // trial of bit K: (m+b)^2 L - m^2 L = b(2S + bL)
        assign lsh = RW'(l_w[j]) << K;
        assign d   = ((s_w[j] << 1) + lsh) << K;
        assign ge  = (r_w[j] >= d);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j] <= ge ? (r_w[j] - d) : r_w[j];
                s_reg[j] <= ge ? (s_w[j] + lsh) : s_w[j];
                m_reg[j] <= ge ? (m_w[j] | (QW'(1) << K)) : m_w[j];
                l_reg[j] <= l_w[j];
            end
        end

        assign r_w[j+1] = r_reg[j];
        assign s_w[j+1] = s_reg[j];
        assign m_w[j+1] = m_reg[j];
        assign l_w[j+1] = l_reg[j];
    end

    // largest odd m below the bound gives q = (m+1)/2, ties away from zero
    assign m_inc = m_w[QW] + QW'(1);
    assign q     = m_inc[QW-1:1];
endmodule
`default_nettype wire

// ----- hw/rtl/triangle_face_normal_top.sv -----
// Top level of the triangle face normal pipeline.
//
// Takes one triangle per request (three Q4.12 corners) and returns its unit
// normal in Q1.14, rounded to nearest with ties away from zero, exact for
// every input; a zero cross product gives a zero normal and degenerate set.
// A request may be accepted in every cycle unless the output stalls; each
// result passes through five arithmetic stages, one stage per bit of the
// 16-bit root recurrence, and the output register. Stalls on the output
// hold the whole pipeline; corner_ready follows normal_ready when full.
`default_nettype none
module triangle_face_normal_top
    import tfn_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       corner_valid,
    output logic                            corner_ready,
    input  wire logic signed [COORD_BITS-1:0] corner0_x,
    input  wire logic signed [COORD_BITS-1:0] corner0_y,
    input  wire logic signed [COORD_BITS-1:0] corner0_z,
    input  wire logic signed [COORD_BITS-1:0] corner1_x,
    input  wire logic signed [COORD_BITS-1:0] corner1_y,
    input  wire logic signed [COORD_BITS-1:0] corner1_z,
    input  wire logic signed [COORD_BITS-1:0] corner2_x,
    input  wire logic signed [COORD_BITS-1:0] corner2_y,
    input  wire logic signed [COORD_BITS-1:0] corner2_z,
    output logic                            normal_valid,
    input  wire logic                       normal_ready,
    output logic signed [NORMAL_W-1:0]      normal_x,
    output logic signed [NORMAL_W-1:0]      normal_y,
    output logic signed [NORMAL_W-1:0]      normal_z,
    output logic                            degenerate
);
    logic                     en;
    logic [NST-1:0]           vld_reg;
    logic signed [EDGE_W-1:0] e1_reg [0:2];
    logic signed [EDGE_W-1:0] e2_reg [0:2];
    logic signed [PROD_W-1:0] p_reg  [0:5];
    logic [MAG_W-1:0]         mag_reg [0:2];
    logic [2:0]               neg3_reg;
    logic                     deg3_reg;
    logic [SQ_W-1:0]          sq4_reg [0:2];
    logic [2:0]               neg4_reg;
    logic                     deg4_reg;
    logic [SQ_W-1:0]          sq5_reg [0:2];
    logic [LEN_W-1:0]         len5_reg;
    logic [2:0]               neg5_reg;
    logic                     deg5_reg;
    logic [2:0]               negd_reg [0:QW-1];
    logic                     degd_reg [0:QW-1];
    logic signed [CROSS_W-1:0] c_w [0:2];
    logic [NORMAL_FRAC_BITS:0] q_w [0:2];
    logic [NORMAL_W-1:0]      n_next [0:2];
    logic signed [NORMAL_W-1:0] nx_reg, ny_reg, nz_reg;
    logic                     deg_reg;

    // whole pipeline advances unless the output holds an unread result
    assign en           = !vld_reg[NST-1] || normal_ready;
    assign corner_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], corner_valid};
    end

    // stage 1: edge vectors
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg[0] <= EDGE_W'(corner1_x) - EDGE_W'(corner0_x);
            e1_reg[1] <= EDGE_W'(corner1_y) - EDGE_W'(corner0_y);
            e1_reg[2] <= EDGE_W'(corner1_z) - EDGE_W'(corner0_z);
            e2_reg[0] <= EDGE_W'(corner2_x) - EDGE_W'(corner0_x);
            e2_reg[1] <= EDGE_W'(corner2_y) - EDGE_W'(corner0_y);
            e2_reg[2] <= EDGE_W'(corner2_z) - EDGE_W'(corner0_z);
        end
    end

    // stage 2: cross product terms
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= e1_reg[1] * e2_reg[2];
            p_reg[1] <= e1_reg[2] * e2_reg[1];
            p_reg[2] <= e1_reg[2] * e2_reg[0];
            p_reg[3] <= e1_reg[0] * e2_reg[2];
            p_reg[4] <= e1_reg[0] * e2_reg[1];
            p_reg[5] <= e1_reg[1] * e2_reg[0];
        end
    end

    // stage 3: components, sign and magnitude
    assign c_w[0] = CROSS_W'(p_reg[0]) - CROSS_W'(p_reg[1]);
    assign c_w[1] = CROSS_W'(p_reg[2]) - CROSS_W'(p_reg[3]);
    assign c_w[2] = CROSS_W'(p_reg[4]) - CROSS_W'(p_reg[5]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i]  <= c_w[i][CROSS_W-1] ? MAG_W'(-c_w[i]) : MAG_W'(c_w[i]);
                neg3_reg[i] <= c_w[i][CROSS_W-1];
            end
            deg3_reg <= (c_w[0] == '0) && (c_w[1] == '0) && (c_w[2] == '0);
        end
    end

    // stage 4: squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                sq4_reg[i] <= mag_reg[i] * mag_reg[i];
            neg4_reg <= neg3_reg;
            deg4_reg <= deg3_reg;
        end
    end

    // stage 5: squared length
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq5_reg  <= sq4_reg;
            len5_reg <= LEN_W'(sq4_reg[0]) + LEN_W'(sq4_reg[1]) + LEN_W'(sq4_reg[2]);
            neg5_reg <= neg4_reg;
            deg5_reg <= deg4_reg;
        end
    end

    // root lanes
    for (genvar i = 0; i < 3; i++) begin : g_lane
        tfn_root u_root (
            .clk  (clk),
            .en   (en),
            .sq   (sq5_reg[i]),
            .len2 (len5_reg),
            .q    (q_w[i])
        );
    end

    // sign and flag travel beside the root lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            negd_reg[0] <= neg5_reg;
            degd_reg[0] <= deg5_reg;
            for (int i = 1; i < QW; i++)
            begin
                negd_reg[i] <= negd_reg[i-1];
                degd_reg[i] <= degd_reg[i-1];
            end
        end
    end

    // output stage: sign, zero on degenerate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_next[i] = NORMAL_W'(q_w[i]);
            if (negd_reg[QW-1][i])
                n_next[i] = -n_next[i];
            if (degd_reg[QW-1])
                n_next[i] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= n_next[0];
            ny_reg  <= n_next[1];
            nz_reg  <= n_next[2];
            deg_reg <= degd_reg[QW-1];
        end
    end

    assign normal_valid = vld_reg[NST-1];
    assign normal_x     = nx_reg;
    assign normal_y     = ny_reg;
    assign normal_z     = nz_reg;
    assign degenerate   = deg_reg;
endmodule
`default_nettype wire
